@@ sv/grm_pkg.sv @@
`timescale 1ns / 1ps

package grm_pkg;

   localparam int SIDE   = 64;
   localparam int SIDE_W = $clog2(SIDE);
   localparam int DIM_W  = SIDE_W + 1;
   localparam int CNT_W  = $clog2(SIDE * SIDE + 1);

   typedef logic [SIDE-1:0] row_bits_type;

   localparam logic [1:0] FUNC_MARK  = 2'd0;
   localparam logic [1:0] FUNC_FETCH = 2'd1;
   localparam logic [1:0] FUNC_CLEAR = 2'd2;

   localparam logic CSR_GRID_WIDTH  = 1'b0;
   localparam logic CSR_GRID_HEIGHT = 1'b1;

   typedef struct packed {
      logic [1:0]        func;
      logic [SIDE_W-1:0] cell_x;
      logic [SIDE_W-1:0] cell_y;
      logic              cell_solid;
   } req_type;

   typedef struct packed {
      logic              rect_valid;
      logic [SIDE_W-1:0] rect_x;
      logic [SIDE_W-1:0] rect_y;
      logic [DIM_W-1:0]  rect_width;
      logic [DIM_W-1:0]  rect_height;
      logic              scan_done;
      logic [CNT_W-1:0]  solid_total;
   } rsp_type;

   typedef struct packed {
      row_bits_type used;
      row_bits_type solid;
   } row_type;

   typedef struct packed {
      logic              clear;
      logic              rd_en;
      logic [SIDE_W-1:0] rd_addr;
      logic              wr_en;
      logic [SIDE_W-1:0] wr_addr;
   } store_ctl_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_MARK_CHK,
      ST_SCAN_RD,
      ST_SCAN_CHK,
      ST_RUN,
      ST_GROW_RD,
      ST_GROW_CHK,
      ST_FILL_RD,
      ST_FILL_WR
   } state_type;

   // bits at and above pos; empty when pos reaches the row width
   function automatic row_bits_type ones_from(input logic [DIM_W-1:0] pos);
      row_bits_type all_ones;
      all_ones = '1;
      if (pos >= DIM_W'(SIDE)) begin
         return '0;
      end
      return all_ones << pos[SIDE_W-1:0];
   endfunction

   function automatic logic [DIM_W-1:0] eff_side(input logic [DIM_W-1:0] v);
      return (v > DIM_W'(SIDE)) ? DIM_W'(SIDE) : v;
   endfunction

endpackage

@@ sv/grm_bitscan.sv @@
`timescale 1ns / 1ps

// Lowest set bit of a row word: pick the first nonzero byte, then the bit.
module grm_bitscan (
   input  grm_pkg::row_bits_type          word,
   output logic                           found,
   output logic [grm_pkg::SIDE_W-1:0]     idx
);

   localparam int GRP   = 8;
   localparam int NGRP  = grm_pkg::SIDE / GRP;
   localparam int GSEL_W = $clog2(NGRP);
   localparam int BSEL_W = $clog2(GRP);

   logic [NGRP-1:0]   grp_any;
   logic [GSEL_W-1:0] grp_sel;
   logic [GRP-1:0]    grp_bits;
   logic [BSEL_W-1:0] bit_sel;

   always_comb begin
      for (int g = 0; g < NGRP; g++) begin
         grp_any[g] = |word[g*GRP +: GRP];
      end
   end

   always_comb begin
      grp_sel = '0;
      for (int g = NGRP - 1; g >= 0; g--) begin
         if (grp_any[g]) begin
            grp_sel = GSEL_W'(g);
         end
      end
   end

   assign grp_bits = word[grp_sel*GRP +: GRP];

   always_comb begin
      bit_sel = '0;
      for (int b = GRP - 1; b >= 0; b--) begin
         if (grp_bits[b]) begin
            bit_sel = BSEL_W'(b);
         end
      end
   end

   assign found = |grp_any;
   assign idx   = {grp_sel, bit_sel};

endmodule

@@ sv/grm_row_store.sv @@
`timescale 1ns / 1ps

// Grid rows {used, solid}; one valid bit per row lets a clear empty all rows together.
module grm_row_store (
   input  logic                   clock,
   input  logic                   reset,
   input  grm_pkg::store_ctl_type ctl,
   input  grm_pkg::row_type       wr_data,
   output grm_pkg::row_type       rd_data
);

   grm_pkg::row_type          mem [grm_pkg::SIDE];
   grm_pkg::row_type          rd_q_ff;
   logic                      rd_vld_ff;
   logic                      rd_vld_in;
   logic [grm_pkg::SIDE-1:0]  vld_ff;
   logic [grm_pkg::SIDE-1:0]  vld_in;

   always_comb begin
      vld_in = vld_ff;
      if (ctl.clear) begin
         vld_in = '0;
      end else if (ctl.wr_en) begin
         vld_in[ctl.wr_addr] = 1'b1;
      end
   end

   always_comb begin
      rd_vld_in = rd_vld_ff;
      if (ctl.rd_en) begin
         rd_vld_in = vld_ff[ctl.rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff    <= '0;
         rd_vld_ff <= 1'b0;
      end else begin
         vld_ff    <= vld_in;
         rd_vld_ff <= rd_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.wr_en) begin
         mem[ctl.wr_addr] <= wr_data;
      end
      if (ctl.rd_en) begin
         rd_q_ff <= mem[ctl.rd_addr];
      end
   end

   // a row never written since the last clear reads as empty
   assign rd_data = rd_vld_ff ? rd_q_ff : '0;

endmodule

@@ sv/greedy_rectangle_merge_top.sv @@
`timescale 1ns / 1ps

// Channel   Ports                          Transfer
// ------    -----------------------------  ------------------------------------
// request   start, busy, req_data          start high while busy low
// result    rsp_valid, rsp_data            rsp_valid high, one cycle, no stall
// config    csr_valid, csr_ready,          csr_valid and csr_ready high
//           csr_addr, csr_wdata
//
// Clear and unused codes answer straight from idle; a cell mark answers after a row read, write.
// A fetch reads and checks each row scanned, takes the run, reads and checks each row probed
// below, stops probing at the grid bottom, and reads and writes each rectangle row marked used;
// a fetch that ends the scan only reads and checks rows, all through the one store port.
// Synchronous active-high reset empties the grid through per-row valid bits.
// Results cannot be held off by the receiver.
module greedy_rectangle_merge_top (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   output logic                         busy,
   input  grm_pkg::req_type             req_data,
   output logic                         rsp_valid,
   output grm_pkg::rsp_type             rsp_data,
   input  logic                         csr_valid,
   output logic                         csr_ready,
   input  logic                         csr_addr,
   input  logic [grm_pkg::DIM_W-1:0]    csr_wdata
);

   localparam int SW = grm_pkg::SIDE_W;
   localparam int DW = grm_pkg::DIM_W;
   localparam int CW = grm_pkg::CNT_W;

   grm_pkg::state_type      state_ff, state_in;
   logic [DW-1:0]           w_reg_ff, w_reg_in;
   logic [DW-1:0]           h_reg_ff, h_reg_in;
   logic [DW-1:0]           scan_row_ff, scan_row_in;
   logic [SW-1:0]           scan_col_ff, scan_col_in;
   logic [CW-1:0]           cnt_ff, cnt_in;
   grm_pkg::req_type        req_ff, req_in;
   logic [DW-1:0]           y_ff, y_in;
   logic [DW-1:0]           x_ff, x_in;
   grm_pkg::row_bits_type   mask_ff, mask_in;
   logic [DW-1:0]           wd_ff, wd_in;
   logic [DW-1:0]           ht_ff, ht_in;
   logic [DW-1:0]           r_ff, r_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   grm_pkg::rsp_type        rsp_data_ff, rsp_data_in;

   grm_pkg::store_ctl_type  store_ctl;
   grm_pkg::row_type        store_wr;
   grm_pkg::row_type        row;
   grm_pkg::row_bits_type   free_bits;
   grm_pkg::row_bits_type   scan_word;
   grm_pkg::row_bits_type   run_word;
   grm_pkg::row_bits_type   unit_word;
   logic                    unit_found;
   logic [SW-1:0]           unit_idx;

   logic                    accept;
   logic [DW-1:0]           w_eff;
   logic [DW-1:0]           h_eff;
   logic [DW-1:0]           run_end;
   logic [DW-1:0]           grow_row;
   logic [DW-1:0]           fill_row;
   logic [DW-1:0]           x_next;
   logic                    mark_hit;
   logic                    grow_fits;
   logic                    fill_last;

   assign accept    = start && !busy;
   assign busy      = (state_ff != grm_pkg::ST_IDLE);
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   assign w_eff     = grm_pkg::eff_side(w_reg_ff);
   assign h_eff     = grm_pkg::eff_side(h_reg_ff);
   assign free_bits = row.solid & ~row.used;

   // scan: first free cell from x inside the grid; run: first blocked cell from x
   assign scan_word = free_bits & grm_pkg::ones_from(x_ff) & ~grm_pkg::ones_from(w_eff);
   assign run_word  = (~free_bits | grm_pkg::ones_from(w_eff)) & grm_pkg::ones_from(x_ff);
   assign unit_word = (state_ff == grm_pkg::ST_RUN) ? run_word : scan_word;
   assign run_end   = unit_found ? {1'b0, unit_idx} : DW'(grm_pkg::SIDE);

   assign grow_row  = y_ff + ht_ff;
   assign fill_row  = y_ff + r_ff;
   assign x_next    = x_ff + DW'(1);
   assign mark_hit  = req_ff.cell_solid && !row.solid[req_ff.cell_x];
   assign grow_fits = ((free_bits & mask_ff) == mask_ff);
   assign fill_last = ((r_ff + DW'(1)) == ht_ff);

   grm_bitscan u_bitscan (
      .word  (unit_word),
      .found (unit_found),
      .idx   (unit_idx)
   );

   grm_row_store u_row_store (
      .clock   (clock),
      .reset   (reset),
      .ctl     (store_ctl),
      .wr_data (store_wr),
      .rd_data (row)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         grm_pkg::ST_IDLE: begin
            if (accept) begin
               if (req_data.func == grm_pkg::FUNC_MARK) begin
                  state_in = grm_pkg::ST_MARK_CHK;
               end else if (req_data.func == grm_pkg::FUNC_FETCH) begin
                  state_in = grm_pkg::ST_SCAN_RD;
               end
            end
         end
         grm_pkg::ST_MARK_CHK: state_in = grm_pkg::ST_IDLE;
         grm_pkg::ST_SCAN_RD: begin
            state_in = (y_ff < h_eff) ? grm_pkg::ST_SCAN_CHK : grm_pkg::ST_IDLE;
         end
         grm_pkg::ST_SCAN_CHK: begin
            state_in = unit_found ? grm_pkg::ST_RUN : grm_pkg::ST_SCAN_RD;
         end
         grm_pkg::ST_RUN: state_in = grm_pkg::ST_GROW_RD;
         grm_pkg::ST_GROW_RD: begin
            state_in = (grow_row < h_eff) ? grm_pkg::ST_GROW_CHK : grm_pkg::ST_FILL_RD;
         end
         grm_pkg::ST_GROW_CHK: begin
            state_in = grow_fits ? grm_pkg::ST_GROW_RD : grm_pkg::ST_FILL_RD;
         end
         grm_pkg::ST_FILL_RD: state_in = grm_pkg::ST_FILL_WR;
         grm_pkg::ST_FILL_WR: begin
            state_in = fill_last ? grm_pkg::ST_IDLE : grm_pkg::ST_FILL_RD;
         end
         default: state_in = grm_pkg::ST_IDLE;
      endcase
   end

   // row store control
   always_comb begin
      store_ctl = '0;
      store_wr  = row;
      unique case (state_ff)
         grm_pkg::ST_IDLE: begin
            if (accept && req_data.func == grm_pkg::FUNC_MARK) begin
               store_ctl.rd_en   = 1'b1;
               store_ctl.rd_addr = req_data.cell_y;
            end else if (accept && req_data.func == grm_pkg::FUNC_CLEAR) begin
               store_ctl.clear = 1'b1;
            end
         end
         grm_pkg::ST_MARK_CHK: begin
            store_ctl.wr_en   = mark_hit;
            store_ctl.wr_addr = req_ff.cell_y;
            store_wr.solid    = row.solid | (grm_pkg::row_bits_type'(1) << req_ff.cell_x);
         end
         grm_pkg::ST_SCAN_RD: begin
            store_ctl.rd_en   = (y_ff < h_eff);
            store_ctl.rd_addr = y_ff[SW-1:0];
         end
         grm_pkg::ST_GROW_RD: begin
            store_ctl.rd_en   = (grow_row < h_eff);
            store_ctl.rd_addr = grow_row[SW-1:0];
         end
         grm_pkg::ST_FILL_RD: begin
            store_ctl.rd_en   = 1'b1;
            store_ctl.rd_addr = fill_row[SW-1:0];
         end
         grm_pkg::ST_FILL_WR: begin
            store_ctl.wr_en   = 1'b1;
            store_ctl.wr_addr = fill_row[SW-1:0];
            store_wr.used     = row.used | mask_ff;
         end
         default: begin
            store_ctl = '0;
         end
      endcase
   end

   // datapath and result
   always_comb begin
      w_reg_in     = w_reg_ff;
      h_reg_in     = h_reg_ff;
      scan_row_in  = scan_row_ff;
      scan_col_in  = scan_col_ff;
      cnt_in       = cnt_ff;
      req_in       = req_ff;
      y_in         = y_ff;
      x_in         = x_ff;
      mask_in      = mask_ff;
      wd_in        = wd_ff;
      ht_in        = ht_ff;
      r_in         = r_ff;
      rsp_valid_in = 1'b0;
      rsp_data_in  = '0;

      if (csr_valid && csr_ready) begin
         if (csr_addr == grm_pkg::CSR_GRID_WIDTH) begin
            w_reg_in = csr_wdata;
         end else begin
            h_reg_in = csr_wdata;
         end
      end

      unique case (state_ff)
         grm_pkg::ST_IDLE: begin
            if (accept) begin
               req_in = req_data;
               if (req_data.func == grm_pkg::FUNC_FETCH) begin
                  y_in = scan_row_ff;
                  x_in = {1'b0, scan_col_ff};
               end else if (req_data.func == grm_pkg::FUNC_CLEAR) begin
                  scan_row_in  = '0;
                  scan_col_in  = '0;
                  cnt_in       = '0;
                  rsp_valid_in = 1'b1;
               end else if (req_data.func != grm_pkg::FUNC_MARK) begin
                  rsp_valid_in = 1'b1;
               end
            end
         end
         grm_pkg::ST_MARK_CHK: begin
            if (mark_hit) begin
               cnt_in = cnt_ff + CW'(1);
            end
            rsp_valid_in = 1'b1;
         end
         grm_pkg::ST_SCAN_RD: begin
            if (y_ff >= h_eff) begin
               rsp_valid_in          = 1'b1;
               rsp_data_in.scan_done = 1'b1;
               scan_col_in           = '0;
               if (scan_row_ff < h_eff) begin
                  scan_row_in = h_eff;
               end
            end
         end
         grm_pkg::ST_SCAN_CHK: begin
            if (unit_found) begin
               x_in = {1'b0, unit_idx};
            end else begin
               y_in = y_ff + DW'(1);
               x_in = '0;
            end
         end
         grm_pkg::ST_RUN: begin
            mask_in = grm_pkg::ones_from(x_ff) & ~grm_pkg::ones_from(run_end);
            wd_in   = run_end - x_ff;
            ht_in   = DW'(1);
         end
         grm_pkg::ST_GROW_RD: begin
            r_in = '0;
         end
         grm_pkg::ST_GROW_CHK: begin
            r_in = '0;
            if (grow_fits) begin
               ht_in = ht_ff + DW'(1);
            end
         end
         grm_pkg::ST_FILL_RD: begin
         end
         grm_pkg::ST_FILL_WR: begin
            r_in = r_ff + DW'(1);
            if (fill_last) begin
               rsp_valid_in            = 1'b1;
               rsp_data_in.rect_valid  = 1'b1;
               rsp_data_in.rect_x      = x_ff[SW-1:0];
               rsp_data_in.rect_y      = y_ff[SW-1:0];
               rsp_data_in.rect_width  = wd_ff;
               rsp_data_in.rect_height = ht_ff;
               // advance past the rectangle's first cell, wrapping at the row end
               if (x_next >= w_eff || x_next >= DW'(grm_pkg::SIDE)) begin
                  scan_col_in = '0;
                  scan_row_in = y_ff + DW'(1);
               end else begin
                  scan_col_in = x_next[SW-1:0];
                  scan_row_in = y_ff;
               end
            end
         end
         default: begin
         end
      endcase

      rsp_data_in.solid_total = cnt_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= grm_pkg::ST_IDLE;
         w_reg_ff     <= DW'(grm_pkg::SIDE);
         h_reg_ff     <= DW'(grm_pkg::SIDE);
         scan_row_ff  <= '0;
         scan_col_ff  <= '0;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         w_reg_ff     <= w_reg_in;
         h_reg_ff     <= h_reg_in;
         scan_row_ff  <= scan_row_in;
         scan_col_ff  <= scan_col_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff      <= req_in;
      y_ff        <= y_in;
      x_ff        <= x_in;
      mask_ff     <= mask_in;
      wd_ff       <= wd_in;
      ht_ff       <= ht_in;
      r_ff        <= r_in;
      rsp_data_ff <= rsp_data_in;
   end

   a_store_write_state: assert property (@(posedge clock) disable iff (reset)
      store_ctl.wr_en |-> (state_ff == grm_pkg::ST_MARK_CHK || state_ff == grm_pkg::ST_FILL_WR))
      else $error("row store written outside a write state");

   a_rect_nonempty: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_data_ff.rect_valid) |->
         (rsp_data_ff.rect_width != '0 && rsp_data_ff.rect_height != '0 &&
          !rsp_data_ff.scan_done))
      else $error("rectangle result with empty extent or done flag");

   a_fill_bounds: assert property (@(posedge clock) disable iff (reset)
      (state_ff == grm_pkg::ST_FILL_WR) |-> (mask_ff != '0 && r_ff < ht_ff))
      else $error("marking pass outside rectangle rows or with empty mask");

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CW'(grm_pkg::SIDE * grm_pkg::SIDE))
      else $error("solid cell count beyond grid capacity");

   a_rsp_cause: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> ($past(accept) || $past(busy)))
      else $error("result strobe without a transfer in flight");

endmodule
